// ===== rtl/pcapd_pkg.sv =====
// pcapd_pkg: shared types, codes and constants of the pcap record deframer.
// No dependencies; imported by every module of the block.
`default_nettype none
package pcapd_pkg;

  localparam int LENGTH_BITS_DEF = 16;

  localparam logic [15:0] MAX_FRAME_RST = 16'd4096;
  localparam logic [31:0] LINK_TYPE_RST = 32'd105;

  localparam int GHDR_BYTES = 24;
  localparam int RHDR_BYTES = 16;
  localparam int MAGIC_POS  = 3;
  localparam int INCL_FIRST = 8;
  localparam int INCL_LAST  = 11;

  localparam logic [31:0] MAGIC_LITTLE = 32'hD4C3B2A1;
  localparam logic [31:0] MAGIC_BIG    = 32'hA1B2C3D4;

  typedef enum logic [0:0] {
    CFG_MAX_FRAME = 1'b0,
    CFG_LINK_TYPE = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    KIND_BYTE = 1'b0,
    KIND_EOF  = 1'b1
  } in_kind_t;

  typedef enum logic [1:0] {
    RK_PAYLOAD = 2'd0,
    RK_EMPTY   = 2'd1,
    RK_STATUS  = 2'd2
  } res_kind_t;

  typedef enum logic [2:0] {
    ST_CLEAN     = 3'd0,
    ST_TRUNCATED = 3'd1,
    ST_OVERSIZED = 3'd2,
    ST_SHORT     = 3'd3,
    ST_MAGIC     = 3'd4,
    ST_LINK      = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] pay;
    logic       last;
    logic [2:0] status;
  } res_t;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/pcap_record_deframer_top.sv =====
// pcap_record_deframer_top: classic pcap file deframer, one file byte per beat.
// Usage:
//   in channel  : in_valid/in_stall with in_kind (0 byte, 1 end of file) and
//                 in_file_byte. One beat is taken per cycle while in_stall is low.
//   out channel : out_valid/out_stall with out_result_kind, out_payload_byte,
//                 out_frame_last and out_end_status. A byte beat gives at most
//                 one result; the end-of-file beat always gives a status.
//   cfg port    : cfg_we/cfg_index/cfg_data write max_frame_length (index 0)
//                 and required_link_type (index 1); write only while idle.
// An accepted beat's result is registered in the result register, or in the skid stage when the receiver stalls.
// Throughput is one beat per cycle while in_stall is low; all per-byte parsing
// is a single compare and shift stage ahead of the result register.
// When the receiver stalls, the result register holds and a one-entry skid
// stage takes one more result; in_stall rises while that stage is occupied.
// Reset (rst_n low, synchronous) returns the parser to the global header,
// empties the output stages and loads the registers with 4096 and 105.
// Depends on pcapd_pkg, pcapd_parse and pcapd_outq.
`default_nettype none
module pcap_record_deframer_top #(
  parameter int LENGTH_BITS = pcapd_pkg::LENGTH_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [0:0]  in_kind,
  input  wire logic [7:0]  in_file_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_payload_byte,
  output logic [0:0]       out_frame_last,
  output logic [2:0]       out_end_status,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import pcapd_pkg::*;

  logic [15:0] max_frame_r;
  logic [31:0] link_type_r;
  logic        in_acc;
  logic        res_valid;
  res_t        res;
  res_t        out_res;
  logic        full;

  assign in_stall = full;
  assign in_acc   = in_valid && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r <= MAX_FRAME_RST;
      link_type_r <= LINK_TYPE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_FRAME: max_frame_r <= cfg_data[15:0];
        CFG_LINK_TYPE: link_type_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  pcapd_parse #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .kind      (in_kind),
    .file_byte (in_file_byte),
    .max_frame (max_frame_r),
    .link_type (link_type_r),
    .res_valid (res_valid),
    .res       (res)
  );

  pcapd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_res  (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_result_kind  = out_res.kind;
  assign out_payload_byte = out_res.pay;
  assign out_frame_last   = out_res.last;
  assign out_end_status   = out_res.status;

endmodule
`default_nettype wire

// ===== rtl/pcapd_parse.sv =====
// pcapd_parse: per-byte parser state and result decode for one input beat.
// Depends on pcapd_pkg.
`default_nettype none
module pcapd_parse #(
  parameter int LENGTH_BITS = pcapd_pkg::LENGTH_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire logic [0:0]        kind,
  input  wire logic [7:0]        file_byte,
  input  wire logic [15:0]       max_frame,
  input  wire logic [31:0]       link_type,
  output logic                   res_valid,
  output pcapd_pkg::res_t        res
);
  import pcapd_pkg::*;

  typedef enum logic [1:0] {
    PH_GLOBAL  = 2'd0,
    PH_RECORD  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_STOPPED = 2'd3
  } phase_t;

  localparam logic [32:0] LEN_LIMIT = (33'd1 << LENGTH_BITS) - 33'd1;

  phase_t                  phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0]  pos_r, pos_nxt;
  logic                    le_r, le_nxt;
  logic [31:0]             word_r, word_nxt;
  logic [LENGTH_BITS-1:0]  flen_r, flen_nxt;
  status_t                 stat_r, stat_nxt;

  logic [31:0]             word_shift;
  logic [31:0]             incl;
  logic                    last;

  assign word_shift = {word_r[23:0], file_byte};
  assign incl       = le_r ? swap32(word_r) : word_r;
  assign last       = ({1'b0, pos_r} + 1'b1) >= {1'b0, flen_r};

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    le_nxt    = le_r;
    word_nxt  = word_r;
    flen_nxt  = flen_r;
    stat_nxt  = stat_r;
    res_valid = 1'b0;
    res       = '0;
    if (acc) begin
      if (kind == KIND_EOF) begin
        res_valid = 1'b1;
        res.kind  = RK_STATUS;
        if (phase_r == PH_STOPPED) begin
          res.status = stat_r;
        end else if (phase_r == PH_GLOBAL) begin
          res.status = ST_SHORT;
        end else if (phase_r == PH_RECORD && pos_r == '0) begin
          res.status = ST_CLEAN;
        end else begin
          res.status = ST_TRUNCATED;
        end
        phase_nxt = PH_GLOBAL;
        pos_nxt   = '0;
        le_nxt    = 1'b0;
        word_nxt  = '0;
        flen_nxt  = '0;
        stat_nxt  = ST_CLEAN;
      end else begin
        case (phase_r)
          PH_GLOBAL: begin
            word_nxt = word_shift;
            pos_nxt  = pos_r + 1'b1;
            if (pos_r == LENGTH_BITS'(MAGIC_POS)) begin
              if (word_shift == MAGIC_LITTLE) begin
                le_nxt = 1'b1;
              end else if (word_shift == MAGIC_BIG) begin
                le_nxt = 1'b0;
              end else begin
                phase_nxt = PH_STOPPED;
                stat_nxt  = ST_MAGIC;
                pos_nxt   = pos_r;
              end
            end
            if (pos_r == LENGTH_BITS'(GHDR_BYTES - 1)) begin
              if ((le_r ? swap32(word_shift) : word_shift) != link_type) begin
                phase_nxt = PH_STOPPED;
                stat_nxt  = ST_LINK;
                pos_nxt   = pos_r;
              end else begin
                phase_nxt = PH_RECORD;
                pos_nxt   = '0;
              end
            end
          end
          PH_RECORD: begin
            if (pos_r >= LENGTH_BITS'(INCL_FIRST) && pos_r <= LENGTH_BITS'(INCL_LAST)) begin
              word_nxt = word_shift;
            end
            if (pos_r == LENGTH_BITS'(RHDR_BYTES - 1)) begin
              pos_nxt = '0;
              if (incl > {16'd0, max_frame} || {1'b0, incl} > LEN_LIMIT) begin
                phase_nxt = PH_STOPPED;
                stat_nxt  = ST_OVERSIZED;
              end else if (incl == '0) begin
                flen_nxt  = '0;
                res_valid = 1'b1;
                res.kind  = RK_EMPTY;
                res.last  = 1'b1;
              end else begin
                flen_nxt  = incl[LENGTH_BITS-1:0];
                phase_nxt = PH_PAYLOAD;
              end
            end else begin
              pos_nxt = pos_r + 1'b1;
            end
          end
          PH_PAYLOAD: begin
            res_valid = 1'b1;
            res.kind  = RK_PAYLOAD;
            res.pay   = file_byte;
            res.last  = last;
            if (last) begin
              phase_nxt = PH_RECORD;
              pos_nxt   = '0;
            end else begin
              pos_nxt = pos_r + 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_GLOBAL;
      pos_r   <= '0;
      le_r    <= 1'b0;
      word_r  <= '0;
      flen_r  <= '0;
      stat_r  <= ST_CLEAN;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      le_r    <= le_nxt;
      word_r  <= word_nxt;
      flen_r  <= flen_nxt;
      stat_r  <= stat_nxt;
    end
  end

`ifndef SYNTHESIS
  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> flen_r != '0)
    else $error("payload phase with zero frame length");
  a_res_on_acc: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> acc)
    else $error("result without an accepted beat");
  a_stopped_status: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_STOPPED |-> stat_r != ST_CLEAN)
    else $error("parsing stopped without an error status");
`endif
endmodule
`default_nettype wire

// ===== rtl/pcapd_outq.sv =====
// pcapd_outq: result register with a one-entry skid stage on the out channel.
// Depends on pcapd_pkg.
`default_nettype none
module pcapd_outq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire pcapd_pkg::res_t push_res,
  output logic                 full,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output pcapd_pkg::res_t      out_res
);
  import pcapd_pkg::*;

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;
  logic take;

  assign take      = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (take) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || take) begin
        out_nxt       = push_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = push_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output is empty");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("beat pushed into a full skid stage");
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && take |=> out_valid_r && !skid_valid_r)
    else $error("skid beat not moved to output");
`endif
endmodule
`default_nettype wire
